@@ rtl/bga_pkg.sv @@
// ----------------------------------------------------------------------------
// bga_pkg: shared types and constants for the bus grant arbiter
// Word layouts, policy and register codes, and parameter defaults.
// ----------------------------------------------------------------------------
package bga_pkg;

  localparam int NUM_REQUESTERS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 16;

  localparam int REQ_W  = 3;
  localparam int HOLD_W = 5;
  localparam int CFG_W  = 5;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_RR   = 1'b1;

  localparam logic CFG_POLICY      = 1'b0;
  localparam logic CFG_MAX_HOLDERS = 1'b1;

  typedef struct packed {
    logic              is_rel;
    logic [REQ_W-1:0]  requester;
  } bga_item_t;

  typedef struct packed {
    logic              policy;
    logic [HOLD_W-1:0] max_holders;
  } bga_cfg_t;

endpackage

@@ rtl/bga_if.sv @@
// ----------------------------------------------------------------------------
// bga_if: event and grant channels
// Valid/ready channels carrying arbiter event words and grant words.
// ----------------------------------------------------------------------------
interface bga_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] requester;

  modport source (output valid, output kind, output requester, input ready);
  modport sink   (input valid, input kind, input requester, output ready);
endinterface

interface bga_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] granted_to;
  logic       dropped;

  modport source (output valid, output granted_to, output dropped, input ready);
  modport sink   (input valid, input granted_to, input dropped, output ready);
endinterface

@@ rtl/bus_grant_arbiter_unit.sv @@
// ----------------------------------------------------------------------------
// bus_grant_arbiter_unit: FIFO / round-robin bus grant arbiter
// Takes acquire and release event words and returns grant words.
//
// in_ch  : event words (kind 0 acquire, 1 release; requester id).
// out_ch : grant words (granted_to, dropped). Zero or one per event.
// cfg_*  : register writes; index 0 policy (0 FIFO, 1 round robin),
//          index 1 max_holders. Write only while the unit is idle.
// An event is registered in the two-entry intake queue, then the grant
// engine takes it. FIFO acquires and rejected events finish in the idle
// state; a FIFO release that hands the grant to a waiter also passes
// through the wait queue RAM read (S_FRD), and a round-robin release with
// requests still pending through the rotating priority pick (S_RPICK).
// The engine takes no new event while in either of these states.
// Reset (synchronous, rst_n low) empties the queues, clears the pending
// mask and holder, and sets policy FIFO with max_holders 1. The wait queue
// RAM is not cleared. While out_ch is stalled the grant word holds; the
// engine takes no further event and the intake fills, then drops ready.
// ----------------------------------------------------------------------------
module bus_grant_arbiter_unit
  import bga_pkg::*;
#(
  parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  bga_in_if.sink           in_ch,
  bga_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  bga_cfg_t  cfg_r;
  logic      item_valid;
  bga_item_t item;
  logic      item_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy      <= POLICY_FIFO;
      cfg_r.max_holders <= HOLD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:      cfg_r.policy      <= cfg_wdata[0];
        CFG_MAX_HOLDERS: cfg_r.max_holders <= cfg_wdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bga_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  bga_back #(
    .NUM_REQUESTERS (NUM_REQUESTERS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/bga_front.sv @@
// ----------------------------------------------------------------------------
// bga_front: event intake
// Accepts event words, decodes the kind and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module bga_front
  import bga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bga_in_if.sink     in_ch,
  output logic       item_valid,
  output bga_item_t  item,
  input  logic       item_pop
);

  bga_item_t  buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  bga_item_t  dec;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign item_valid  = (cnt_r != 2'd0);
  assign pop         = item_pop && item_valid;
  assign item        = buf_r[rd_ptr_r];

  always_comb begin
    dec.is_rel    = (in_ch.kind == KIND_RELEASE);
    dec.requester = in_ch.requester;
    wr_ptr_nxt    = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt    = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt       = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ rtl/bga_back.sv @@
// ----------------------------------------------------------------------------
// bga_back: grant engine
// Executes queued events under the FIFO or round-robin policy and drives
// the registered grant word.
// ----------------------------------------------------------------------------
module bga_back
  import bga_pkg::*;
#(
  parameter int NUM_REQUESTERS = NUM_REQUESTERS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bga_cfg_t   cfg,
  input  logic       item_valid,
  input  bga_item_t  item,
  output logic       item_pop,
  bga_out_if.source  out_ch
);

  localparam int RW = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_FRD, S_RPICK} state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [NUM_REQUESTERS-1:0] pend_r, pend_nxt;
  logic [NUM_REQUESTERS-1:0] rot_r, rot_nxt;
  logic [RW-1:0]         ptr_r, ptr_nxt;
  logic [RW-1:0]         holder_r, holder_nxt;
  logic                  hvalid_r, hvalid_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [REQ_W-1:0]      ogrant_r, ogrant_nxt;
  logic                  odrop_r, odrop_nxt;

  logic [REQ_W-1:0]      mem [QUEUE_DEPTH];
  logic [REQ_W-1:0]      rd_data_r;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;

  logic                  out_free;
  logic [HOLD_W-1:0]     m;
  logic [AW:0]           tail_sum, rd_sum;
  logic [AW-1:0]         head_inc;
  logic [RW-1:0]         req_idx;
  logic [NUM_REQUESTERS-1:0] pend_rel;
  logic [2*NUM_REQUESTERS-1:0] dbl;
  logic [RW-1:0]         first;
  logic [RW:0]           pick_sum;
  logic [RW-1:0]         pick;
  logic [RW-1:0]         req_plus1, pick_plus1;

  assign out_free          = !ovalid_r || out_ch.ready;
  assign out_ch.valid      = ovalid_r;
  assign out_ch.granted_to = ogrant_r;
  assign out_ch.dropped    = odrop_r;

  always_comb begin
    m        = (cfg.max_holders == '0) ? HOLD_W'(1) : cfg.max_holders;
    tail_sum = (AW+1)'(head_r) + (AW+1)'(count_r);
    wr_addr  = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
               AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
    rd_sum   = (AW+1)'(head_inc) + (AW+1)'(m) - (AW+1)'(1);
    rd_addr  = (rd_sum >= (AW+1)'(QUEUE_DEPTH)) ?
               AW'(rd_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(rd_sum);
    req_idx  = RW'(item.requester);
    req_plus1 = (req_idx == RW'(NUM_REQUESTERS - 1)) ? '0 : req_idx + RW'(1);
    pend_rel = pend_r & ~(NUM_REQUESTERS'(1) << holder_r);
    dbl      = {pend_rel, pend_rel} >> ptr_r;
  end

  always_comb begin
    first = '0;
    for (int i = NUM_REQUESTERS - 1; i >= 0; i--) begin
      if (rot_r[i]) begin
        first = RW'(i);
      end
    end
    pick_sum   = (RW+1)'(ptr_r) + (RW+1)'(first);
    pick       = (pick_sum >= (RW+1)'(NUM_REQUESTERS)) ?
                 RW'(pick_sum - (RW+1)'(NUM_REQUESTERS)) : RW'(pick_sum);
    pick_plus1 = (pick == RW'(NUM_REQUESTERS - 1)) ? '0 : pick + RW'(1);
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pend_nxt   = pend_r;
    rot_nxt    = rot_r;
    ptr_nxt    = ptr_r;
    holder_nxt = holder_r;
    hvalid_nxt = hvalid_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ogrant_nxt = ogrant_r;
    odrop_nxt  = odrop_r;
    item_pop   = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (item_valid && out_free) begin
          item_pop = 1'b1;
          if (cfg.policy == POLICY_FIFO) begin
            if (!item.is_rel) begin
              if (32'(count_r) >= QUEUE_DEPTH) begin
                ovalid_nxt = 1'b1;
                ogrant_nxt = '0;
                odrop_nxt  = 1'b1;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
                if (32'(count_r) + 1 <= 32'(m)) begin
                  ovalid_nxt = 1'b1;
                  ogrant_nxt = item.requester;
                  odrop_nxt  = 1'b0;
                end
              end
            end else if (count_r != '0) begin
              head_nxt  = head_inc;
              count_nxt = count_r - CW'(1);
              if (32'(count_r) - 1 >= 32'(m)) begin
                rd_en     = 1'b1;
                state_nxt = S_FRD;
              end
            end
          end else begin
            if (!item.is_rel) begin
              if (32'(item.requester) < NUM_REQUESTERS && !pend_r[req_idx]) begin
                pend_nxt[req_idx] = 1'b1;
                if (!hvalid_r) begin
                  holder_nxt = req_idx;
                  hvalid_nxt = 1'b1;
                  ptr_nxt    = req_plus1;
                  ovalid_nxt = 1'b1;
                  ogrant_nxt = item.requester;
                  odrop_nxt  = 1'b0;
                end
              end
            end else if (hvalid_r) begin
              pend_nxt = pend_rel;
              if (pend_rel == '0) begin
                hvalid_nxt = 1'b0;
              end else begin
                rot_nxt   = dbl[NUM_REQUESTERS-1:0];
                state_nxt = S_RPICK;
              end
            end
          end
        end
      end
      S_FRD: begin
        ovalid_nxt = 1'b1;
        ogrant_nxt = rd_data_r;
        odrop_nxt  = 1'b0;
        state_nxt  = S_IDLE;
      end
      S_RPICK: begin
        holder_nxt = pick;
        ptr_nxt    = pick_plus1;
        ovalid_nxt = 1'b1;
        ogrant_nxt = REQ_W'(pick);
        odrop_nxt  = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      count_r  <= '0;
      pend_r   <= '0;
      ptr_r    <= '0;
      holder_r <= '0;
      hvalid_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      pend_r   <= pend_nxt;
      ptr_r    <= ptr_nxt;
      holder_r <= holder_nxt;
      hvalid_r <= hvalid_nxt;
      ovalid_r <= ovalid_nxt;
    end
    rot_r    <= rot_nxt;
    ogrant_r <= ogrant_nxt;
    odrop_r  <= odrop_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item.requester;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
